/* rtl/core/id3v2_text_frame_parser_macros.svh */
// ------------------------------------------------------------------------
// id3v2 text frame parser assertion macros
// shared concurrent assertion forms for the checker
// ------------------------------------------------------------------------
`ifndef ID3V2_TEXT_FRAME_PARSER_MACROS_SVH
`define ID3V2_TEXT_FRAME_PARSER_MACROS_SVH

// assertion that is off while reset is high
`define ID3TP_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: assertion failed");

// assertion that also runs through reset
`define ID3TP_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");

`endif

/* rtl/core/id3tp_pkg.sv */
// ------------------------------------------------------------------------
// id3tp_pkg
// shared types, codes and tables of the id3v2 text frame parser
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

package id3tp_pkg;

  localparam logic [1:0] KIND_FIELD = 2'd0;
  localparam logic [1:0] KIND_TEXT  = 2'd1;
  localparam logic [1:0] KIND_EOF   = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_HDR = 2'd1;
  localparam logic [1:0] ST_BAD_VER = 2'd2;

  localparam logic [2:0] FIELD_NONE = 3'd7;
  localparam int         NUM_FIELDS = 5;

  localparam logic [3:0] HEADER_LEN    = 4'd10;
  localparam logic [3:0] FRAME_HDR_LEN = 4'd10;

  localparam logic [7:0] VERSION_RESET = 8'd3;
  localparam logic       REG_VERSION   = 1'b0;

  localparam int QUEUE_DEPTH = 4;
  localparam int Q_AW        = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] MAGIC [3] = '{8'h49, 8'h44, 8'h33};

  localparam logic [31:0] TEXT_IDS [NUM_FIELDS] = '{
    32'h54495432, 32'h54504531, 32'h54414C42, 32'h54594552, 32'h54434F4E
  };

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] field;
    logic [7:0] text_byte;
    logic [1:0] status;
  } result_t;

  // results caused by one input byte
  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } bundle_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [2:0] lookup_field(input logic [31:0] id);
    logic [2:0] f;
    f = FIELD_NONE;
    for (int i = 0; i < NUM_FIELDS; i++) begin
      if (TEXT_IDS[i] == id) f = 3'(i);
    end
    return f;
  endfunction

endpackage

/* rtl/core/id3v2_text_frame_parser.sv */
// ------------------------------------------------------------------------
// id3v2_text_frame_parser
// id3v2 header check and text frame extraction, while in_stall is low one file byte per cycle
// ------------------------------------------------------------------------
// latency: a taken byte's results pass the bundle queue, then the output register
// throughput: one byte per cycle while in_stall is low, set by the one-byte parser step
// a last byte with two results sends them through the output register one after the other
// the four-entry bundle queue stalls input only when the output is held
// synchronous reset empties the queue and restores version_wanted to 3
`timescale 1ns / 1ps

module id3v2_text_frame_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [2:0]  field,
  output logic [7:0]  text_byte,
  output logic [1:0]  status,
  output logic        last_of_run
);
  import id3tp_pkg::*;

  logic [7:0] version_wanted;
  logic       accept;
  logic       push;
  logic       pop;
  bundle_t    push_data;
  bundle_t    head;
  q_stat_t    stat;
  result_t    res;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_VERSION) ? {24'd0, version_wanted} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      version_wanted <= VERSION_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_VERSION) begin
      version_wanted <= pwdata[7:0];
    end
  end

  assign in_stall = stat.full;
  assign accept   = in_valid && !in_stall;

  id3tp_front u_front (
    .clk            (clk),
    .rst            (rst),
    .version_wanted (version_wanted),
    .accept         (accept),
    .data_byte      (data_byte),
    .last_byte      (last_byte),
    .push           (push),
    .bundle         (push_data)
  );

  id3tp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .stat      (stat)
  );

  id3tp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .stat        (stat),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .res         (res),
    .last_of_run (last_of_run)
  );

  assign kind      = res.kind;
  assign field     = res.field;
  assign text_byte = res.text_byte;
  assign status    = res.status;

endmodule

/* rtl/core/id3tp_front.sv */
// ------------------------------------------------------------------------
// id3tp_front
// accepts file bytes, tracks header and frame state, builds result bundles
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

module id3tp_front (
  input  logic              clk,
  input  logic              rst,
  input  logic [7:0]        version_wanted,
  input  logic              accept,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  output logic              push,
  output id3tp_pkg::bundle_t bundle
);
  import id3tp_pkg::*;

  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_FRAME   = 2'd1;
  localparam logic [1:0] PH_PAYLOAD = 2'd2;
  localparam logic [1:0] PH_FAILED  = 2'd3;

  logic [1:0]  phase, phase_next;
  logic [3:0]  pos, pos_next;
  logic [31:0] ident, ident_next;
  logic [31:0] left, left_next;
  logic [2:0]  cur_field, cur_field_next;
  logic        text_done, text_done_next;
  logic        enc_skipped, enc_skipped_next;

  result_t     res [2];
  logic [1:0]  n_res;
  logic [2:0]  found;

  always_comb begin
    phase_next       = phase;
    pos_next         = pos;
    ident_next       = ident;
    left_next        = left;
    cur_field_next   = cur_field;
    text_done_next   = text_done;
    enc_skipped_next = enc_skipped;
    res[0]           = '0;
    res[1]           = '0;
    n_res            = 2'd0;
    found            = lookup_field(ident);

    unique case (phase)
      PH_HEADER: begin
        if (pos < 4'd3 && data_byte != MAGIC[pos[1:0]]) begin
          res[0]     = '{kind: KIND_EOF, field: 3'd0, text_byte: 8'd0, status: ST_BAD_HDR};
          n_res      = 2'd1;
          phase_next = PH_FAILED;
        end else if (pos == 4'd3 && data_byte != version_wanted) begin
          res[0]     = '{kind: KIND_EOF, field: 3'd0, text_byte: 8'd0, status: ST_BAD_VER};
          n_res      = 2'd1;
          phase_next = PH_FAILED;
        end else if (pos == HEADER_LEN - 4'd1) begin
          pos_next   = 4'd0;
          phase_next = PH_FRAME;
        end else begin
          pos_next = pos + 4'd1;
        end
      end
      PH_FRAME: begin
        if (pos < 4'd4) ident_next = {ident[23:0], data_byte};
        else if (pos < 4'd8) left_next = {left[23:0], data_byte};
        if (pos == FRAME_HDR_LEN - 4'd1) begin
          pos_next         = 4'd0;
          cur_field_next   = found;
          text_done_next   = 1'b0;
          enc_skipped_next = 1'b0;
          if (found != FIELD_NONE) begin
            res[0] = '{kind: KIND_FIELD, field: found, text_byte: 8'd0, status: ST_OK};
            n_res  = 2'd1;
          end
          if (left != 32'd0) phase_next = PH_PAYLOAD;
        end else begin
          pos_next = pos + 4'd1;
        end
      end
      PH_PAYLOAD: begin
        if (cur_field != FIELD_NONE) begin
          if (!enc_skipped) begin
            enc_skipped_next = 1'b1;
          end else if (!text_done) begin
            if (data_byte == 8'd0) begin
              text_done_next = 1'b1;
            end else begin
              res[0] = '{kind: KIND_TEXT, field: cur_field, text_byte: data_byte,
                         status: ST_OK};
              n_res  = 2'd1;
            end
          end
        end
        left_next = left - 32'd1;
        if (left == 32'd1) phase_next = PH_FRAME;
      end
      PH_FAILED: begin
      end
      default: begin
      end
    endcase

    if (last_byte) begin
      if (phase_next != PH_FAILED) begin
        res[n_res[0]] = '{kind: KIND_EOF, field: 3'd0, text_byte: 8'd0,
                          status: (phase_next == PH_HEADER && pos_next <= 4'd3) ?
                                  ST_BAD_HDR : ST_OK};
        n_res = n_res + 2'd1;
      end
      phase_next       = PH_HEADER;
      pos_next         = 4'd0;
      ident_next       = 32'd0;
      left_next        = 32'd0;
      cur_field_next   = FIELD_NONE;
      text_done_next   = 1'b0;
      enc_skipped_next = 1'b0;
    end
  end

  assign push         = accept && (n_res != 2'd0);
  assign bundle.count = n_res;
  assign bundle.r0    = res[0];
  assign bundle.r1    = res[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HEADER;
      pos         <= 4'd0;
      ident       <= 32'd0;
      left        <= 32'd0;
      cur_field   <= FIELD_NONE;
      text_done   <= 1'b0;
      enc_skipped <= 1'b0;
    end else if (accept) begin
      phase       <= phase_next;
      pos         <= pos_next;
      ident       <= ident_next;
      left        <= left_next;
      cur_field   <= cur_field_next;
      text_done   <= text_done_next;
      enc_skipped <= enc_skipped_next;
    end
  end

endmodule

/* rtl/core/id3tp_queue.sv */
// ------------------------------------------------------------------------
// id3tp_queue
// short bundle queue between the parser front and the output back
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

module id3tp_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  id3tp_pkg::bundle_t push_data,
  input  logic               pop,
  output id3tp_pkg::bundle_t head,
  output id3tp_pkg::q_stat_t stat
);
  import id3tp_pkg::*;

  bundle_t         q [QUEUE_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_AW:0]   cnt;

  assign head       = q[rd_ptr];
  assign stat.full  = (cnt == (Q_AW+1)'(QUEUE_DEPTH));
  assign stat.empty = (cnt == '0);

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) cnt <= cnt + 1'b1;
      else if (pop && !push) cnt <= cnt - 1'b1;
    end
  end

endmodule

/* rtl/core/id3tp_back.sv */
// ------------------------------------------------------------------------
// id3tp_back
// unpacks queued bundles into single results behind an output register
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

module id3tp_back (
  input  logic               clk,
  input  logic               rst,
  input  id3tp_pkg::bundle_t head,
  input  id3tp_pkg::q_stat_t stat,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output id3tp_pkg::result_t res,
  output logic               last_of_run
);
  import id3tp_pkg::*;

  logic sub;
  logic load;
  logic is_last;

  assign load    = !stat.empty && (!out_valid || !out_stall);
  assign is_last = sub || (head.count == 2'd1);
  assign pop     = load && is_last;

  always_ff @(posedge clk) begin
    if (load) begin
      res         <= sub ? head.r1 : head.r0;
      last_of_run <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sub       <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
      sub       <= !is_last;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

/* rtl/core/id3tp_checker.sv */
// ------------------------------------------------------------------------
// id3tp_checker
// port-level checks of the id3v2 text frame parser, bound to the top level
// ------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "id3v2_text_frame_parser_macros.svh"

module id3tp_checker (
  input logic        clk,
  input logic        rst,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready,
  input logic        in_valid,
  input logic        in_stall,
  input logic [7:0]  data_byte,
  input logic        last_byte,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  kind,
  input logic [2:0]  field,
  input logic [7:0]  text_byte,
  input logic [1:0]  status,
  input logic        last_of_run
);
  import id3tp_pkg::*;

  // stalled result transaction holds
  `ID3TP_ASSERT(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(kind) && $stable(field) && $stable(text_byte) && $stable(status) && $stable(last_of_run))
  // end of file closes the run of its byte
  `ID3TP_ASSERT(a_eof_last, clk, rst, out_valid && kind == KIND_EOF |-> last_of_run)
  // register write reads back
  `ID3TP_ASSERT(a_cfg_rdback, clk, rst, psel && penable && pwrite && pready && !paddr[2] |=> paddr[2] || prdata[7:0] == $past(pwdata[7:0]))
  // reset empties the queue and output
  `ID3TP_ASSERT_ALWAYS(a_rst_empty, clk, rst |=> !out_valid && !in_stall)

endmodule

bind id3v2_text_frame_parser id3tp_checker u_chk (.*);

/* test/tb_top.sv */
// ------------------------------------------------------------------------
// tb_top
// self-checking bench for the id3v2 text frame parser: ID3 files are fed
// one byte per transaction, a cycle-free parser model predicts the field
// starts, text bytes and end-of-file status, and each output transaction
// is compared in order; when enabled, pacing on both sides is random per transaction
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import id3tp_pkg::*;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] field;
    logic [7:0] text_byte;
    logic [1:0] status;
    logic       last_of_run;
  } tag_result_t;

  localparam logic [1:0] PH_HDR     = 2'd0;
  localparam logic [1:0] PH_FRM_HDR = 2'd1;
  localparam logic [1:0] PH_PAYLOAD = 2'd2;
  localparam logic [1:0] PH_FAILED  = 2'd3;

  localparam logic [2:0]  ADDR_VERSION  = 3'({REG_VERSION, 2'b00});
  localparam logic [7:0]  CH_I          = 8'h49;
  localparam logic [7:0]  CH_D          = 8'h44;
  localparam logic [7:0]  CH_3          = 8'h33;
  localparam logic [7:0]  ID3_MAGIC [3] = '{CH_I, CH_D, CH_3};
  localparam logic [31:0] ID_TIT2       = 32'h54495432;
  localparam logic [31:0] ID_TPE1       = 32'h54504531;
  localparam logic [31:0] ID_TALB       = 32'h54414C42;
  localparam logic [31:0] ID_TYER       = 32'h54594552;
  localparam logic [31:0] ID_TCON       = 32'h54434F4E;
  localparam logic [31:0] ID_COMM       = 32'h434F4D4D;
  localparam logic [31:0] TEXT_FRAME_IDS [5] = '{ID_TIT2, ID_TPE1, ID_TALB, ID_TYER, ID_TCON};
  localparam logic [2:0]  FIELD_UNSET   = 3'd7;
  localparam logic [3:0]  TAG_HDR_LEN   = 4'd10;
  localparam logic [3:0]  FRM_HDR_LEN   = 4'd10;
  localparam int          SETTLE_CYCLES = 8;
  localparam int          MAX_PRINTS    = 100;
  localparam int          RANDOM_BYTES  = 150;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = '0;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  kind;
  logic [2:0]  field;
  logic [7:0]  text_byte;
  logic [1:0]  status;
  logic        last_of_run;

  // parser model state
  logic [7:0]   ver_model = VERSION_RESET;
  logic [1:0]   ph = PH_HDR;
  logic [3:0]   pos = '0;
  logic [31:0]  ident = '0;
  logic [31:0]  left = '0;
  logic [2:0]   cur_field = FIELD_UNSET;
  logic         text_done = 1'b0;
  logic         enc_skipped = 1'b0;

  tag_result_t  tag_results_q[$];
  logic [7:0]   file_bytes[$];
  logic [7:0]   payload_bytes[$];
  int           errors = 0;
  int           bytes_sent = 0;
  bit           gap_on = 1'b0;
  bit           stall_on = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  id3v2_text_frame_parser u_dut (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .data_byte   (data_byte),
    .last_byte   (last_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kind        (kind),
    .field       (field),
    .text_byte   (text_byte),
    .status      (status),
    .last_of_run (last_of_run)
  );

  task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
    errors++;
    if (errors <= MAX_PRINTS) begin
      $display("%0t mismatch %s: got %0h expected %0h", $time, what, got, want);
    end
  endtask

  function automatic void clear_parse();
    ph = PH_HDR;
    pos = '0;
    ident = '0;
    left = '0;
    cur_field = FIELD_UNSET;
    text_done = 1'b0;
    enc_skipped = 1'b0;
  endfunction

  function automatic tag_result_t mk_result(input logic [1:0] k, input logic [2:0] f,
                                            input logic [7:0] t, input logic [1:0] s);
    tag_result_t r;
    r = '{kind: k, field: f, text_byte: t, status: s, last_of_run: 1'b0};
    return r;
  endfunction

  function automatic logic [2:0] field_of_id(input logic [31:0] id);
    logic [2:0] f;
    f = FIELD_UNSET;
    for (int i = 0; i < 5; i++) begin
      if (TEXT_FRAME_IDS[i] == id) f = 3'(i);
    end
    return f;
  endfunction

  // one file byte through the parser model, results go to tag_results_q
  function automatic void parse_tag_byte(input logic [7:0] b, input logic last);
    tag_result_t run[$];
    logic        failed_now;
    logic [1:0]  st;
    failed_now = 1'b0;
    case (ph)
      PH_HDR: begin
        if (pos < 4'd3 && b != ID3_MAGIC[pos[1:0]]) begin
          run.push_back(mk_result(KIND_EOF, 3'd0, 8'h00, ST_BAD_HDR));
          ph = PH_FAILED;
          failed_now = 1'b1;
        end else if (pos == 4'd3 && b != ver_model) begin
          run.push_back(mk_result(KIND_EOF, 3'd0, 8'h00, ST_BAD_VER));
          ph = PH_FAILED;
          failed_now = 1'b1;
        end else begin
          pos = pos + 4'd1;
          if (pos >= TAG_HDR_LEN) begin
            pos = '0;
            ph = PH_FRM_HDR;
          end
        end
      end
      PH_FRM_HDR: begin
        if (pos < 4'd4) ident = {ident[23:0], b};
        else if (pos < 4'd8) left = {left[23:0], b};
        pos = pos + 4'd1;
        if (pos >= FRM_HDR_LEN) begin
          pos = '0;
          cur_field = field_of_id(ident);
          text_done = 1'b0;
          enc_skipped = 1'b0;
          if (cur_field != FIELD_UNSET) begin
            run.push_back(mk_result(KIND_FIELD, cur_field, 8'h00, ST_OK));
          end
          if (left != 0) ph = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        if (cur_field != FIELD_UNSET) begin
          if (!enc_skipped) begin
            enc_skipped = 1'b1;
          end else if (!text_done) begin
            if (b == 8'h00) text_done = 1'b1;
            else run.push_back(mk_result(KIND_TEXT, cur_field, b, ST_OK));
          end
        end
        left = left - 32'd1;
        if (left == 0) ph = PH_FRM_HDR;
      end
      default: ;
    endcase
    if (last) begin
      if (!failed_now && ph != PH_FAILED) begin
        st = (ph == PH_HDR && pos <= 4'd3) ? ST_BAD_HDR : ST_OK;
        run.push_back(mk_result(KIND_EOF, 3'd0, 8'h00, st));
      end
      clear_parse();
    end
    if (run.size() > 0) run[run.size() - 1].last_of_run = 1'b1;
    foreach (run[i]) tag_results_q.push_back(run[i]);
  endfunction

  // output side: random stall per result transaction while stall_on is set
  initial begin
    int hold;
    forever begin
      hold = stall_on ? $urandom_range(19, 0) : 0;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    tag_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (tag_results_q.size() == 0) begin
        report("unexpected result, kind", 8'(kind), 8'h00);
      end else begin
        want = tag_results_q.pop_front();
        if (kind !== want.kind) report("kind", 8'(kind), 8'(want.kind));
        if (field !== want.field) report("field", 8'(field), 8'(want.field));
        if (text_byte !== want.text_byte) report("text_byte", text_byte, want.text_byte);
        if (status !== want.status) report("status", 8'(status), 8'(want.status));
        if (last_of_run !== want.last_of_run) begin
          report("last_of_run", 8'(last_of_run), 8'(want.last_of_run));
        end
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = gap_on ? $urandom_range(19, 0) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    last_byte <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    parse_tag_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_file();
    foreach (file_bytes[i]) send_byte(file_bytes[i], i == file_bytes.size() - 1);
    file_bytes.delete();
  endtask

  // hold the input until every predicted result is out, then let the pipe settle
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (tag_results_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic check_version();
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ADDR_VERSION;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[7:0] !== ver_model) report("version readback", prdata[7:0], ver_model);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_version(input logic [7:0] v);
    wait_for_results();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_VERSION;
    pwdata <= 32'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    ver_model = v;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    check_version();
  endtask

  task automatic put_header(input logic [7:0] v);
    file_bytes.push_back(CH_I);
    file_bytes.push_back(CH_D);
    file_bytes.push_back(CH_3);
    file_bytes.push_back(v);
    repeat (6) file_bytes.push_back(8'($urandom));
  endtask

  // frame header with the given size, then whatever sits in payload_bytes
  task automatic put_frame(input logic [31:0] id, input logic [31:0] size);
    for (int i = 3; i >= 0; i--) file_bytes.push_back(id[8*i +: 8]);
    for (int i = 3; i >= 0; i--) file_bytes.push_back(size[8*i +: 8]);
    repeat (2) file_bytes.push_back(8'($urandom));
    foreach (payload_bytes[i]) file_bytes.push_back(payload_bytes[i]);
    payload_bytes.delete();
  endtask

  task automatic put_text(input logic [7:0] enc, input string s);
    payload_bytes.push_back(enc);
    foreach (s[i]) payload_bytes.push_back(8'(s[i]));
  endtask

  task automatic test_register_reset();
    check_version();
  endtask

  task automatic test_header_checks();
    gap_on = 1'b1;
    stall_on = 1'b1;
    file_bytes = '{8'h58};
    send_file();
    file_bytes = '{CH_I, 8'h00, 8'hFF};
    send_file();
    file_bytes = '{CH_I, CH_D, 8'h34, CH_3};
    send_file();
    file_bytes = '{CH_I, CH_D, CH_3, 8'h02, 8'h00};
    send_file();
    file_bytes = '{CH_I, CH_D};
    send_file();
    file_bytes = '{CH_I, CH_D, CH_3};
    send_file();
    file_bytes = '{CH_I, CH_D, CH_3, ver_model};
    send_file();
    file_bytes = '{CH_I, CH_D, CH_3, ver_model, 8'h00, 8'h80};
    send_file();
  endtask

  task automatic test_text_frames();
    gap_on = 1'b0;
    stall_on = 1'b0;
    put_header(ver_model);
    put_text(8'h00, "Ab");
    put_frame(ID_TIT2, payload_bytes.size());
    put_frame(ID_TPE1, 32'd0);
    payload_bytes.push_back(8'h01);
    put_frame(ID_TALB, payload_bytes.size());
    put_text(8'h03, "19");
    payload_bytes.push_back(8'h00);
    payload_bytes.push_back(8'h58);
    put_frame(ID_TYER, payload_bytes.size());
    payload_bytes = '{8'hFF, 8'hFF, 8'h80, 8'h7F, 8'h01};
    put_frame(ID_TCON, payload_bytes.size());
    put_text(8'h00, "zz");
    put_frame(ID_COMM, payload_bytes.size());
    put_text(8'h00, "C");
    put_frame(ID_TIT2, payload_bytes.size());
    // size far beyond the file, ends on a text byte
    put_text(8'h00, "Q");
    put_frame(ID_TPE1, 32'hFF000003);
    send_file();
    // file ends on the last flag byte of a text frame
    gap_on = 1'b1;
    stall_on = 1'b1;
    put_header(ver_model);
    put_frame(ID_TCON, 32'd0);
    send_file();
    // file ends inside a frame header
    put_header(ver_model);
    put_frame(ID_COMM, 32'd0);
    file_bytes.push_back(8'h54);
    file_bytes.push_back(8'h49);
    send_file();
  endtask

  task automatic test_version_setting();
    write_version(8'h00);
    put_header(8'h00);
    put_text(8'h00, "xy");
    put_frame(ID_TYER, payload_bytes.size());
    send_file();
    file_bytes = '{CH_I, CH_D, CH_3, 8'h03, 8'h00};
    send_file();
    write_version(8'hFF);
    put_header(8'hFF);
    put_text(8'h01, "k");
    put_frame(ID_TCON, payload_bytes.size());
    send_file();
    file_bytes = '{CH_I, CH_D, CH_3, 8'hFE, 8'h11};
    send_file();
    write_version(8'($urandom));
    put_header(ver_model);
    put_text(8'h00, "mid");
    put_frame(ID_TALB, payload_bytes.size());
    send_file();
    write_version(VERSION_RESET);
  endtask

  task automatic build_random_file();
    int          style;
    int          len;
    int          cut;
    logic [31:0] id;
    style = $urandom_range(99, 0);
    if (style < 75) begin
      put_header(($urandom_range(9, 0) == 0) ? 8'($urandom) : ver_model);
      repeat ($urandom_range(4, 1)) begin
        id = ($urandom_range(9, 0) < 7) ? TEXT_FRAME_IDS[$urandom_range(4, 0)]
                                        : 32'($urandom);
        len = ($urandom_range(9, 0) == 0) ? 0 : $urandom_range(14, 1);
        repeat (len) begin
          payload_bytes.push_back(($urandom_range(11, 0) == 0) ? 8'h00
                                                               : 8'($urandom_range(255, 1)));
        end
        put_frame(id, payload_bytes.size());
      end
      if ($urandom_range(4, 0) == 0) begin
        repeat ($urandom_range(6, 0)) payload_bytes.push_back(8'($urandom));
        put_frame(TEXT_FRAME_IDS[$urandom_range(4, 0)], 32'($urandom) | 32'h01000000);
      end
      if ($urandom_range(5, 0) == 0) begin
        cut = $urandom_range(file_bytes.size() - 1, 1);
        while (file_bytes.size() > cut) void'(file_bytes.pop_back());
      end
    end else if (style < 90) begin
      // good prefix, then a byte that may break the header
      cut = $urandom_range(3, 0);
      for (int i = 0; i < cut; i++) file_bytes.push_back(ID3_MAGIC[i]);
      file_bytes.push_back(8'($urandom));
      repeat ($urandom_range(5, 0)) file_bytes.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(8, 1)) file_bytes.push_back(8'($urandom));
    end
  endtask

  task automatic test_random_files();
    int start;
    int files;
    start = bytes_sent;
    files = 0;
    while (bytes_sent - start < RANDOM_BYTES) begin
      gap_on = ($urandom_range(2, 0) != 0);
      stall_on = ($urandom_range(2, 0) != 0);
      if (files % 6 == 5) begin
        case ($urandom_range(3, 0))
          0: write_version(8'h00);
          1: write_version(8'hFF);
          2: write_version(VERSION_RESET);
          default: write_version(8'($urandom));
        endcase
      end
      if (files == 2) begin
        stall_on = 1'b1;
        wait_for_results();
      end
      build_random_file();
      send_file();
      files++;
    end
  endtask

  initial begin
    clear_parse();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_register_reset();
    test_header_checks();
    test_text_frames();
    test_version_setting();
    test_random_files();
    wait_for_results();
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
